// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out under NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that expr holds at every edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error("assertion failed");

// Check that cons holds at the edge where ante holds.
`define ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds at the edge after the one where ante holds.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, clk, rst_n, expr)
`define ASSERT_SAME(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/aip_pkg.sv =====
// ---------------------------------------------------------------------------
// ASCII integer parser package
// Field widths, character codes, parse phases, number forms and digit decode.
// ---------------------------------------------------------------------------
package aip_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_W           = 32;
  localparam int FORM_W          = 2;
  localparam int PHASE_W         = 3;
  localparam int CHAR_W          = 8;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [FORM_W-1:0] form_t;
  typedef logic [PHASE_W-1:0] phase_t;

  localparam char_t CHAR_MINUS = 8'h2D;  // '-'
  localparam char_t CHAR_ZERO  = 8'h30;  // '0'
  localparam char_t CHAR_NINE  = 8'h39;  // '9'
  localparam char_t CHAR_X_LO  = 8'h78;  // 'x'
  localparam char_t CHAR_X_UP  = 8'h58;  // 'X'
  localparam char_t CHAR_A_LO  = 8'h61;  // 'a'
  localparam char_t CHAR_F_LO  = 8'h66;  // 'f'
  localparam char_t CHAR_A_UP  = 8'h41;  // 'A'
  localparam char_t CHAR_F_UP  = 8'h46;  // 'F'
  localparam char_t CHAR_QUOTE = 8'h27;  // '\''

  localparam phase_t PH_IDLE  = 3'd0;
  localparam phase_t PH_LEAD  = 3'd1;
  localparam phase_t PH_ZERO  = 3'd2;
  localparam phase_t PH_DEC   = 3'd3;
  localparam phase_t PH_HEX   = 3'd4;
  localparam phase_t PH_QUOTE = 3'd5;

  localparam form_t FORM_DEC   = 2'd0;
  localparam form_t FORM_HEX   = 2'd1;
  localparam form_t FORM_QUOTE = 2'd2;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t dec_digit(char_t c);
    digit_t d;
    d.ok  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    d.val = c[3:0];
    return d;
  endfunction

  function automatic digit_t hex_digit(char_t c);
    digit_t d;
    char_t  t;
    d.ok  = 1'b0;
    d.val = 4'd0;
    if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
      d.ok  = 1'b1;
      d.val = c[3:0];
    end else if ((c >= CHAR_A_LO) && (c <= CHAR_F_LO)) begin
      t     = c - CHAR_A_LO + 8'd10;
      d.ok  = 1'b1;
      d.val = t[3:0];
    end else if ((c >= CHAR_A_UP) && (c <= CHAR_F_UP)) begin
      t     = c - CHAR_A_UP + 8'd10;
      d.ok  = 1'b1;
      d.val = t[3:0];
    end
    return d;
  endfunction

endpackage

// ===== rtl/ascii_integer_parser.sv =====
// ---------------------------------------------------------------------------
// ASCII integer parser
// Converts a byte stream into signed integers: decimal, 0x hex or quoted.
// ---------------------------------------------------------------------------
// Usage:
//  Input channel: one text byte per word on char_byte_i, begins_i flags the
//  first byte of a string. A word moves when in_valid_i is high and in_stall_o
//  is low. An optional '-', then "0x"/"0X" hex digits, a quote and one byte,
//  or decimal digits. The first byte that does not fit ends the number and
//  yields one result word; later bytes are dropped until the next flagged one.
//  Output channel: value_o and number_form_o move when out_valid_o is high and
//  out_stall_i is low.
//  Throughput: one byte per cycle while in_stall_o is low; the per-byte
//  update (shift or times ten plus an add into the accumulator) completes in
//  the cycle the byte is taken. The result of a terminating byte is
//  registered in the output register, or in the skid register if that waits.
//  Stall: a skid register holds one result while the output register waits,
//  so input keeps flowing; in_stall_o rises only when both are full.
//  Reset: asynchronous, clears the phase to idle and empties both registers.
// ---------------------------------------------------------------------------
module ascii_integer_parser #(
  parameter int VALUE_WIDTH = aip_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [aip_pkg::CHAR_W-1:0]          char_byte_i,
  input  logic                                begins_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [aip_pkg::OUT_W-1:0]    value_o,
  output logic [aip_pkg::FORM_W-1:0]          number_form_o
);
  import aip_pkg::*;

  typedef logic [VALUE_WIDTH-1:0] acc_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    form_t                   form;
  } result_t;

  phase_t  phase_q, phase_d;
  logic    neg_q, neg_d;
  acc_t    acc_q, acc_d;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;

  logic    in_fire, out_fire;
  logic    emit;
  form_t   emit_form;
  acc_t    emit_mag, emit_val;
  result_t res;

  phase_t  eff_phase;
  logic    eff_neg;
  acc_t    eff_acc;
  digit_t  dd, hd;
  acc_t    dec_next, hex_next;

  assign in_fire  = in_valid_i & ~in_stall_o;
  assign out_fire = out_valid_q & ~out_stall_i;

  assign dd = dec_digit(char_byte_i);
  assign hd = hex_digit(char_byte_i);

  // A flagged byte restarts the conversion from a clean state.
  assign eff_phase = begins_i ? PH_LEAD : phase_q;
  assign eff_neg   = begins_i ? 1'b0 : neg_q;
  assign eff_acc   = begins_i ? '0 : acc_q;

  assign dec_next = {eff_acc[VALUE_WIDTH-4:0], 3'b000}
                  + {eff_acc[VALUE_WIDTH-2:0], 1'b0}
                  + VALUE_WIDTH'(dd.val);
  assign hex_next = {eff_acc[VALUE_WIDTH-5:0], hd.val};

  always_comb begin
    phase_d   = eff_phase;
    neg_d     = eff_neg;
    acc_d     = eff_acc;
    emit      = 1'b0;
    emit_form = FORM_DEC;
    emit_mag  = eff_acc;
    if (begins_i && (char_byte_i == CHAR_MINUS)) begin
      neg_d = 1'b1;
    end else begin
      unique case (eff_phase) inside
        PH_LEAD, PH_ZERO, PH_DEC: begin
          if ((eff_phase == PH_LEAD) && (char_byte_i == CHAR_ZERO)) begin
            phase_d = PH_ZERO;
          end else if ((eff_phase == PH_LEAD) && (char_byte_i == CHAR_QUOTE)) begin
            phase_d = PH_QUOTE;
          end else if ((eff_phase == PH_ZERO) &&
                       ((char_byte_i == CHAR_X_LO) || (char_byte_i == CHAR_X_UP))) begin
            phase_d = PH_HEX;
          end else if (dd.ok) begin
            acc_d   = dec_next;
            phase_d = PH_DEC;
          end else begin
            emit    = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_HEX: begin
          if (hd.ok) begin
            acc_d = hex_next;
          end else begin
            emit      = 1'b1;
            emit_form = FORM_HEX;
            phase_d   = PH_IDLE;
          end
        end
        PH_QUOTE: begin
          emit      = 1'b1;
          emit_form = FORM_QUOTE;
          emit_mag  = VALUE_WIDTH'(char_byte_i);
          phase_d   = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  assign emit_val  = eff_neg ? (acc_t'(0) - emit_mag) : emit_mag;
  assign res.value = OUT_W'($signed(emit_val));
  assign res.form  = emit_form;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
    end
  end

  // Output register plus one skid entry; the skid drains first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && emit) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && emit) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o    = skid_valid_q;
  assign out_valid_o   = out_valid_q;
  assign value_o       = out_q.value;
  assign number_form_o = out_q.form;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_skid_behind_out, clk_i, rst_ni, !skid_valid_q || out_valid_q)
  `ASSERT_SAME(a_skid_on_stall, clk_i, rst_ni, $rose(skid_valid_q),
               $past(out_valid_q && out_stall_i))
  `ASSERT_NEXT(a_emit_to_idle, clk_i, rst_ni, in_fire && emit, phase_q == PH_IDLE)
  `ASSERT_NEXT(a_minus_sets_neg, clk_i, rst_ni,
               in_fire && begins_i && (char_byte_i == CHAR_MINUS),
               neg_q && (phase_q == PH_LEAD) && (acc_q == '0))

endmodule

// ===== tb/sv/ascii_integer_parser_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ASCII integer parser testbench
// Feeds directed and random text strings into the parser, tracks the parse in
// a scoreboard that computes each number, and checks every result word
// against it under phases of sender idling and receiver stalling.
// ---------------------------------------------------------------------------
module ascii_integer_parser_test;
  import aip_pkg::*;

  localparam int RANDOM_BYTES = 1850;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    logic [OUT_W-1:0] value;
    form_t            form;
  } number_t;

  class parse_scoreboard;
    phase_t           stage;
    bit               negate;
    logic [OUT_W-1:0] acc;
    number_t          expected_numbers[$];
    int               errors;

    function new();
      stage  = PH_IDLE;
      negate = 1'b0;
      acc    = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_numbers.size();
    endfunction

    function void finish_number(logic [OUT_W-1:0] mag, form_t form);
      number_t n;
      n.value = negate ? -mag : mag;
      n.form  = form;
      expected_numbers.push_back(n);
      stage = PH_IDLE;
    endfunction

    function void decimal_byte(char_t c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        acc   = acc * 32'd10 + 32'(c - CHAR_ZERO);
        stage = PH_DEC;
      end else begin
        finish_number(acc, FORM_DEC);
      end
    endfunction

    // Returns 1 when the word takes part in a parse, 0 when the block drops it.
    function bit take_byte(char_t c, bit first);
      bit         live;
      bit         ok;
      logic [3:0] nib;
      live = first || (stage != PH_IDLE);
      if (first) begin
        negate = 1'b0;
        acc    = '0;
        stage  = PH_LEAD;
        if (c == CHAR_MINUS) begin
          negate = 1'b1;
          return live;
        end
      end
      case (stage)
        PH_LEAD: begin
          if (c == CHAR_ZERO) stage = PH_ZERO;
          else if (c == CHAR_QUOTE) stage = PH_QUOTE;
          else decimal_byte(c);
        end
        PH_ZERO: begin
          if (c == CHAR_X_LO || c == CHAR_X_UP) stage = PH_HEX;
          else decimal_byte(c);
        end
        PH_DEC: decimal_byte(c);
        PH_HEX: begin
          ok  = 1'b1;
          nib = c[3:0];
          // letters a-f / A-F carry 1..6 in their low bits
          if ((c >= CHAR_A_LO && c <= CHAR_F_LO) || (c >= CHAR_A_UP && c <= CHAR_F_UP))
            nib = 4'd9 + 4'(c[2:0]);
          else if (!(c >= CHAR_ZERO && c <= CHAR_NINE))
            ok = 1'b0;
          if (ok) acc = {acc[OUT_W-5:0], nib};
          else finish_number(acc, FORM_HEX);
        end
        PH_QUOTE: finish_number({{(OUT_W-CHAR_W){1'b0}}, c}, FORM_QUOTE);
        default: stage = PH_IDLE;
      endcase
      return live;
    endfunction

    function void check_result(logic [OUT_W-1:0] value, form_t form);
      number_t n;
      if (expected_numbers.size() == 0) begin
        $error("unexpected result word: value %0d, number_form %0d", $signed(value), form);
        errors++;
        return;
      end
      n = expected_numbers.pop_front();
      if (value !== n.value) begin
        $error("value: expected %0d, got %0d", $signed(n.value), $signed(value));
        errors++;
      end
      if (form !== n.form) begin
        $error("number_form: expected %0d, got %0d", n.form, form);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [CHAR_W-1:0]       char_byte_i = '0;
  logic                    begins_i    = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] value_o;
  logic [FORM_W-1:0]       number_form_o;

  parse_scoreboard sb = new();
  int idle_pct   = 0;
  int stall_pct  = 0;
  int live_count = 0;
  int quiet      = 0;

  ascii_integer_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_byte_i   (char_byte_i),
    .begins_i      (begins_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .number_form_o (number_form_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Sample both channels mid-cycle, where inputs and outputs are settled.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      quiet++;
      if (in_valid_i && !in_stall_o) begin
        quiet = 0;
        if (sb.take_byte(char_byte_i, begins_i)) live_count++;
      end
      if (out_valid_o && !out_stall_i) begin
        quiet = 0;
        sb.check_result(value_o, number_form_o);
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("ascii_integer_parser test failed");
        $finish;
      end
    end
  end

  task automatic send_word(char_t c, bit first);
    bit took;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i  <= 1'b0;
      char_byte_i <= 8'($urandom_range(0, 255));
      begins_i    <= 1'($urandom_range(0, 1));
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    begins_i    <= first;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic send_string(string s, char_t term);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == 0);
    send_word(term, s.len() == 0);
  endtask

  function automatic char_t hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return CHAR_ZERO + 8'(k);
    if (k < 16) return CHAR_A_LO + 8'(k - 10);
    return CHAR_A_UP + 8'(k - 16);
  endfunction

  // Mostly well-formed strings with random content; some noise, some cut short.
  task automatic send_random_string();
    char_t text[$];
    int    kind;
    int    n;
    if ($urandom_range(0, 99) < 10) begin
      send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      return;
    end
    if ($urandom_range(0, 3) == 0) text.push_back(CHAR_MINUS);
    kind = $urandom_range(0, 3);
    case (kind)
      0: begin
        n = $urandom_range(0, ($urandom_range(0, 7) == 0) ? 12 : 6);
        repeat (n) text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      1: begin
        text.push_back(CHAR_ZERO);
        text.push_back($urandom_range(0, 1) ? CHAR_X_LO : CHAR_X_UP);
        n = $urandom_range(0, ($urandom_range(0, 7) == 0) ? 10 : 6);
        repeat (n) text.push_back(hex_char());
      end
      2: begin
        text.push_back(CHAR_QUOTE);
        text.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        text.push_back(CHAR_ZERO);
        n = $urandom_range(0, 5);
        repeat (n) text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
    endcase
    // the quoted byte ends its own number
    if (kind != 2) text.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, text.size());
      while (text.size() > n) void'(text.pop_back());
    end else if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
    end
    foreach (text[i]) send_word(text[i], i == 0);
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // dropped: nothing flagged yet
    send_word("7", 1'b0);
    send_string("", 8'h00);
    send_string("-", 8'h00);
    send_string("-", "x");
    send_string("0x", 8'h00);
    send_string("0X", "g");
    send_string("07", "z");
    send_string("123", 8'h00);
    send_string("-45", " ");
    send_string("2147483647", 8'h00);
    send_string("-2147483648", 8'h00);
    send_string("4294967296", 8'h00);
    send_string("99999999999", ";");
    send_string("0xFFFFFFFF", 8'h00);
    send_string("-0x80000000", 8'h00);
    send_string("0x123456789", 8'h00);
    send_string("0xabcdef", "G");
    send_string("0XABCDEF", "g");
    send_string("'", "A");
    send_string("'", 8'h00);
    send_string("-'", 8'hFF);
    send_string("'", "'");
    send_string("5", "-");
    send_string("8", 8'h80);
    // dropped: trails a finished number
    send_word("9", 1'b0);
    // abandon unfinished parses, the second by a flagged minus
    send_word("1", 1'b1);
    send_word("2", 1'b0);
    send_word("3", 1'b1);
    send_word("-", 1'b1);
    send_string("9", 8'h00);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      target = live_count + RANDOM_BYTES / 4;
      while (live_count < target) send_random_string();
    end
    // abandon any open parse; the flagged terminator yields a zero of its own
    send_string("", 8'h00);
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ascii_integer_parser test passed");
    end else begin
      $display("ascii_integer_parser test failed");
    end
    $finish;
  end

endmodule
